// ----- src/tpd_pkg.sv -----
// Package with the shared types and constants of the torus point distance block.
package tpd_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int AXIS_FRAC     = 15;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int FIFO_DEPTH    = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_AXIS_X   = 3'd3,
      REG_AXIS_Y   = 3'd4,
      REG_AXIS_Z   = 3'd5,
      REG_MAJOR    = 3'd6,
      REG_MINOR    = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      MODE_DIST   = 2'd0,
      MODE_SQUARE = 2'd1,
      MODE_TEST   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic signed [31:0]  point_x;
      logic signed [31:0]  point_y;
      logic signed [31:0]  point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  distance_value;
      logic                inside_flag;
      logic                saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0]  center_x;
      logic signed [31:0]  center_y;
      logic signed [31:0]  center_z;
      logic signed [15:0]  axis_x;
      logic signed [15:0]  axis_y;
      logic signed [15:0]  axis_z;
      logic [30:0]         major_radius;
      logic [30:0]         minor_radius;
   } cfg_type;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      mode_type            mode;
      logic signed [32:0]  nx;
      logic signed [32:0]  ny;
      logic signed [32:0]  nz;
   } item_type;

endpackage

// ----- src/tpd_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a side band.
module tpd_sqrt #(
   parameter int IW = 68,
   parameter int SW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [IW-1:0]      in_x,
   input  logic [SW-1:0]      in_side,
   output logic               out_valid,
   output logic [IW/2-1:0]    out_root,
   output logic [SW-1:0]      out_side
);
   localparam int OW = IW / 2;

   logic [IW-1:0] rem_ff  [0:OW];
   logic [OW-1:0] root_ff [0:OW];
   logic [SW-1:0] side_ff [0:OW];
   logic          vld_ff  [0:OW];

   always_ff @(posedge clock) begin
      rem_ff[0]  <= in_x;
      root_ff[0] <= '0;
      side_ff[0] <= in_side;
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar k = 0; k < OW; k++) begin : g_stage
      localparam int BI = OW - 1 - k;
      logic [IW-1:0] trial;
      logic          take;
      always_comb begin
         trial = (IW'(root_ff[k]) << (BI + 1)) | (IW'(1) << (2 * BI));
         take  = rem_ff[k] >= trial;
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= take ? rem_ff[k] - trial : rem_ff[k];
         root_ff[k+1] <= take ? (root_ff[k] | (OW'(1) << BI)) : root_ff[k];
         side_ff[k+1] <= side_ff[k];
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[OW];
   assign out_root  = root_ff[OW];
   assign out_side  = side_ff[OW];
endmodule

// ----- src/tpd_fifo.sv -----
// Short queue between the front and the back of the pipeline.
module tpd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpd_pkg::item_type   push_data,
   input  logic                pop,
   output tpd_pkg::item_type   pop_data,
   output logic                not_empty,
   output logic                almost_full
);
   localparam int AW = $clog2(tpd_pkg::FIFO_DEPTH);

   tpd_pkg::item_type mem_ff [0:tpd_pkg::FIFO_DEPTH-1];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_pop;

   always_comb begin
      do_pop = pop && (cnt_ff != '0);
      wr_in  = push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign pop_data    = mem_ff[rd_ff];
   assign not_empty   = cnt_ff != '0;
   // One place is held back for the item already in the front register.
   assign almost_full = cnt_ff >= (AW+1)'(tpd_pkg::FIFO_DEPTH - 1);
endmodule

// ----- src/tpd_front.sv -----
// Front end: takes the query, classifies the mode and centers the point.
module tpd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  tpd_pkg::req_type    req,
   input  tpd_pkg::cfg_type    cfg,
   output logic                push,
   output tpd_pkg::item_type   item
);
   tpd_pkg::req_type req_ff;
   logic             vld_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= accept;
      end
   end

   always_comb begin
      unique case (req_ff.mode)
         tpd_pkg::MODE_DIST:   item.mode = tpd_pkg::MODE_DIST;
         tpd_pkg::MODE_SQUARE: item.mode = tpd_pkg::MODE_SQUARE;
         default:              item.mode = tpd_pkg::MODE_TEST;
      endcase
      item.nx = 33'(req_ff.point_x) - 33'(cfg.center_x);
      item.ny = 33'(req_ff.point_y) - 33'(cfg.center_y);
      item.nz = 33'(req_ff.point_z) - 33'(cfg.center_z);
   end

   assign push = vld_ff;
endmodule

// ----- src/tpd_back.sv -----
// Back end: projections, two square roots and the result formatting.
module tpd_back #(
   parameter int FRAC_BITS = tpd_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  tpd_pkg::item_type   item,
   input  tpd_pkg::cfg_type    cfg,
   output logic                rsp_valid,
   output tpd_pkg::rsp_type    rsp
);
   // Stage 1: products.
   logic signed [48:0] px_ff, py_ff, pz_ff;
   logic signed [65:0] sx_ff, sy_ff, sz_ff;
   tpd_pkg::mode_type  m1_ff;
   logic               v1_ff;
   // Stage 2: axial coordinate and squared length.
   logic signed [34:0] a_ff;
   logic [66:0]        d_ff;
   tpd_pkg::mode_type  m2_ff;
   logic               v2_ff;
   logic signed [50:0] t_sum;
   logic signed [50:0] t_rnd;
   // Stage 3: a squared.
   logic [67:0]        z2_ff;
   logic [66:0]        d3_ff;
   tpd_pkg::mode_type  m3_ff;
   logic               v3_ff;
   logic signed [69:0] a_sq;
   // Stage 4: radial argument.
   logic [67:0]        y_ff;
   logic [67:0]        z4_ff;
   tpd_pkg::mode_type  m4_ff;
   logic               v4_ff;
   // First root.
   logic               r1_valid;
   logic [33:0]        rho;
   logic [69:0]        r1_side;
   // Stage 5 and 6.
   logic [68:0]        qq_ff;
   logic [67:0]        z5_ff;
   tpd_pkg::mode_type  m5_ff;
   logic               v5_ff;
   logic signed [35:0] q_val;
   logic signed [71:0] q_sq;
   logic [70:0]        w_ff;
   logic               in6_ff;
   tpd_pkg::mode_type  m6_ff;
   logic               v6_ff;
   logic [70:0]        w_sum;
   logic [61:0]        s2_ff;
   // Second root.
   logic               r2_valid;
   logic [35:0]        e_root;
   logic [2:0]         r2_side;
   // Stage 7 to 9.
   logic signed [37:0] diff_ff;
   logic               in7_ff;
   tpd_pkg::mode_type  m7_ff;
   logic               v7_ff;
   logic signed [37:0] diff;
   logic [73:0]        sq_ff;
   logic signed [37:0] diff8_ff;
   logic               in8_ff;
   tpd_pkg::mode_type  m8_ff;
   logic               v8_ff;
   logic [36:0]        g_val;
   logic [73:0]        sq_rnd;
   tpd_pkg::rsp_type   rsp_in, rsp_ff;
   logic               v9_ff;

   always_comb begin
      t_sum = 51'(px_ff) + 51'(py_ff) + 51'(pz_ff);
      t_rnd = t_sum + (51'(1) <<< (tpd_pkg::AXIS_FRAC - 1));
      a_sq  = 70'(a_ff) * 70'(a_ff);
      q_val = 36'(cfg.major_radius) - 36'(rho);
      q_sq  = 72'(q_val) * 72'(q_val);
      w_sum = 71'(qq_ff) + 71'(z5_ff);
      diff  = 38'(e_root) - 38'(cfg.minor_radius);
      g_val = diff_ff[36:0];
      sq_rnd = sq_ff + (74'(1) << (FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      px_ff <= item.nx * 49'(cfg.axis_x);
      py_ff <= item.ny * 49'(cfg.axis_y);
      pz_ff <= item.nz * 49'(cfg.axis_z);
      sx_ff <= item.nx * item.nx;
      sy_ff <= item.ny * item.ny;
      sz_ff <= item.nz * item.nz;
      m1_ff <= item.mode;

      a_ff  <= 35'(t_rnd >>> tpd_pkg::AXIS_FRAC);
      d_ff  <= 67'(unsigned'(sx_ff)) + 67'(unsigned'(sy_ff)) + 67'(unsigned'(sz_ff));
      m2_ff <= m1_ff;

      z2_ff <= a_sq[67:0];
      d3_ff <= d_ff;
      m3_ff <= m2_ff;

      y_ff  <= (68'(d3_ff) > z2_ff) ? 68'(d3_ff) - z2_ff : '0;
      z4_ff <= z2_ff;
      m4_ff <= m3_ff;

      qq_ff <= q_sq[68:0];
      z5_ff <= r1_side[69:2];
      m5_ff <= tpd_pkg::mode_type'(r1_side[1:0]);

      s2_ff  <= 62'(cfg.minor_radius) * 62'(cfg.minor_radius);
      w_ff   <= w_sum;
      in6_ff <= w_sum <= 71'(s2_ff);
      m6_ff  <= m5_ff;

      diff_ff <= diff;
      in7_ff  <= r2_side[2];
      m7_ff   <= tpd_pkg::mode_type'(r2_side[1:0]);

      sq_ff    <= 74'(g_val) * 74'(g_val);
      diff8_ff <= diff_ff;
      in8_ff   <= in7_ff;
      m8_ff    <= m7_ff;

      rsp_ff <= rsp_in;

      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= r1_valid;
         v6_ff <= v5_ff;
         v7_ff <= r2_valid;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   tpd_sqrt #(.IW(68), .SW(70)) u_sqrt_rho (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_x     (y_ff),
      .in_side  ({z4_ff, m4_ff}),
      .out_valid(r1_valid),
      .out_root (rho),
      .out_side (r1_side)
   );

   tpd_sqrt #(.IW(72), .SW(3)) u_sqrt_e (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v6_ff),
      .in_x     ({1'b0, w_ff}),
      .in_side  ({in6_ff, m6_ff}),
      .out_valid(r2_valid),
      .out_root (e_root),
      .out_side (r2_side)
   );

   always_comb begin
      rsp_in.distance_value = '0;
      rsp_in.inside_flag    = in8_ff;
      rsp_in.saturated      = 1'b0;
      case (m8_ff)
         tpd_pkg::MODE_DIST: begin
            if (diff8_ff > 38'sd2147483647) begin
               rsp_in.distance_value = 32'sh7FFFFFFF;
               rsp_in.saturated      = 1'b1;
            end else if (diff8_ff < -38'sd2147483648) begin
               rsp_in.distance_value = 32'sh80000000;
               rsp_in.saturated      = 1'b1;
            end else begin
               rsp_in.distance_value = diff8_ff[31:0];
            end
         end
         tpd_pkg::MODE_SQUARE: begin
            if (!diff8_ff[37]) begin
               if ((sq_rnd >> FRAC_BITS) > 74'h7FFFFFFF) begin
                  rsp_in.distance_value = 32'sh7FFFFFFF;
                  rsp_in.saturated      = 1'b1;
               end else begin
                  rsp_in.distance_value = 32'(sq_rnd >> FRAC_BITS);
               end
            end
         end
         default: begin
            rsp_in.distance_value = '0;
         end
      endcase
   end

   assign rsp_valid = v9_ff;
   assign rsp       = rsp_ff;
endmodule

// ----- src/torus_point_distance_top.sv -----
// Top level of the torus point distance block.
//
//  channel   ports                            transfer at
//  request   start, busy, req_data            start high and busy low
//  response  rsp_valid, rsp_data              every cycle rsp_valid is high
//  config    csr_we, csr_index, csr_wdata     every cycle csr_we is high
//
// One query may be started in every cycle while busy is low; each gives one
// response. Most stages are in the two square roots, one result bit per stage.
// Reset is synchronous and clears the registers to the unit torus on the z axis.
// The response cannot be held off; busy rises only if the queue is almost full.
module torus_point_distance_top #(
   parameter int FRAC_BITS = tpd_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  tpd_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output tpd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [tpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   tpd_pkg::cfg_type  cfg_ff;
   tpd_pkg::item_type f_item, q_item;
   logic              f_push, q_nonempty, q_afull, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x     <= '0;
         cfg_ff.center_y     <= '0;
         cfg_ff.center_z     <= '0;
         cfg_ff.axis_x       <= '0;
         cfg_ff.axis_y       <= '0;
         cfg_ff.axis_z       <= 16'sd32767;
         cfg_ff.major_radius <= 31'd65536;
         cfg_ff.minor_radius <= 31'd65536;
      end else if (csr_we) begin
         unique case (tpd_pkg::reg_idx_type'(csr_index))
            tpd_pkg::REG_CENTER_X: cfg_ff.center_x     <= csr_wdata;
            tpd_pkg::REG_CENTER_Y: cfg_ff.center_y     <= csr_wdata;
            tpd_pkg::REG_CENTER_Z: cfg_ff.center_z     <= csr_wdata;
            tpd_pkg::REG_AXIS_X:   cfg_ff.axis_x       <= csr_wdata[15:0];
            tpd_pkg::REG_AXIS_Y:   cfg_ff.axis_y       <= csr_wdata[15:0];
            tpd_pkg::REG_AXIS_Z:   cfg_ff.axis_z       <= csr_wdata[15:0];
            tpd_pkg::REG_MAJOR:    cfg_ff.major_radius <= csr_wdata[30:0];
            tpd_pkg::REG_MINOR:    cfg_ff.minor_radius <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign busy   = q_afull;
   assign accept = start && !busy;

   tpd_front u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .cfg   (cfg_ff),
      .push  (f_push),
      .item  (f_item)
   );

   tpd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_data  (f_item),
      .pop        (1'b1),
      .pop_data   (q_item),
      .not_empty  (q_nonempty),
      .almost_full(q_afull)
   );

   tpd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_nonempty),
      .item     (q_item),
      .cfg      (cfg_ff),
      .rsp_valid(rsp_valid),
      .rsp      (rsp_data)
   );
endmodule

// ----- src/tpd_checker.sv -----
// Port-level assertions for the torus point distance block, bound to the top level.
module tpd_assertions (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input tpd_pkg::rsp_type  rsp_data
);
   // A response never follows a reset cycle directly.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response right after reset");

   // A clipped value sits at one of the two range limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.distance_value == 32'sh7FFFFFFF ||
         rsp_data.distance_value == 32'sh80000000)
      else $error("saturated value not at a limit");

   // A negative distance means the point is inside the tube.
   a_neg_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.distance_value[31] |-> rsp_data.inside_flag)
      else $error("negative distance but not inside");

   // The pipeline drains every cycle, so the request side never backs up.
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
endmodule

bind torus_point_distance_top tpd_assertions u_tpd_assertions (
   .clock    (clock),
   .reset    (reset),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);

// ----- sim/tpd_checker.sv -----
// Checker for the torus point distance block: predicts each response and compares it.
`timescale 1ns / 100ps

module tpd_checker
   import tpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_count,
   output int                     result_count
);

   longint ctr_x, ctr_y, ctr_z;
   longint ax_x, ax_y, ax_z;
   longint rad_major, rad_minor;
   rsp_type expected_rsps[$];
   int fails;
   int checked;

   function automatic logic [127:0] square_of(input longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= x)
            r = c;
      end
      return r;
   endfunction

   function automatic rsp_type torus_query(input req_type q);
      longint nx, ny, nz, t, a, q_rad, e, val;
      logic [127:0] d, a2, y, w, sq;
      logic [63:0] rho;
      rsp_type r;
      nx = longint'(q.point_x) - ctr_x;
      ny = longint'(q.point_y) - ctr_y;
      nz = longint'(q.point_z) - ctr_z;
      t = nx * ax_x + ny * ax_y + nz * ax_z;
      a = (t + (longint'(1) << (AXIS_FRAC - 1))) >>> AXIS_FRAC;
      d = square_of(nx) + square_of(ny) + square_of(nz);
      a2 = square_of(a);
      // The radial argument can go negative with an axis longer than unit.
      y = (d > a2) ? d - a2 : '0;
      rho = floor_sqrt(y);
      q_rad = rad_major - longint'(rho);
      w = square_of(q_rad) + a2;
      e = longint'(floor_sqrt(w));
      r.inside_flag = (w <= square_of(rad_minor));
      r.saturated = 1'b0;
      val = 0;
      case (q.mode)
         MODE_DIST: begin
            val = e - rad_minor;
            if (val > 64'sd2147483647) begin
               val = 64'sd2147483647;
               r.saturated = 1'b1;
            end else if (val < -64'sd2147483648) begin
               val = -64'sd2147483648;
               r.saturated = 1'b1;
            end
         end
         MODE_SQUARE: begin
            if (e >= rad_minor) begin
               sq = (square_of(e - rad_minor) + (128'd1 << (FRAC_BITS_DEF - 1)))
                    >> FRAC_BITS_DEF;
               if (sq > 128'd2147483647) begin
                  val = 64'sd2147483647;
                  r.saturated = 1'b1;
               end else begin
                  val = longint'(sq[63:0]);
               end
            end
         end
         default: val = 0;
      endcase
      r.distance_value = val[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ctr_x = 0; ctr_y = 0; ctr_z = 0;
         ax_x = 0; ax_y = 0; ax_z = 32767;
         rad_major = 65536; rad_minor = 65536;
         expected_rsps.delete();
         fails = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            case (reg_idx_type'(csr_index))
               REG_CENTER_X: ctr_x = longint'($signed(csr_wdata));
               REG_CENTER_Y: ctr_y = longint'($signed(csr_wdata));
               REG_CENTER_Z: ctr_z = longint'($signed(csr_wdata));
               REG_AXIS_X:   ax_x = longint'($signed(csr_wdata[15:0]));
               REG_AXIS_Y:   ax_y = longint'($signed(csr_wdata[15:0]));
               REG_AXIS_Z:   ax_z = longint'($signed(csr_wdata[15:0]));
               REG_MAJOR:    rad_major = longint'({33'd0, csr_wdata[30:0]});
               REG_MINOR:    rad_minor = longint'({33'd0, csr_wdata[30:0]});
               default: ;
            endcase
         end
         if (rsp_valid) begin
            checked++;
            if (expected_rsps.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: response with none outstanding: %h", $realtime, rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.distance_value !== want.distance_value
                   || rsp_data.inside_flag !== want.inside_flag
                   || rsp_data.saturated !== want.saturated) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: mismatch: expected dist %0d in %b sat %b, got %0d %b %b",
                              $realtime, want.distance_value, want.inside_flag,
                              want.saturated, rsp_data.distance_value,
                              rsp_data.inside_flag, rsp_data.saturated);
               end
            end
         end
         if (start && !busy)
            expected_rsps.push_back(torus_query(req_data));
      end
      pending_count <= expected_rsps.size();
      fail_count <= fails;
      result_count <= checked;
   end

endmodule

// ----- sim/torus_point_distance_top_tb.sv -----
// Testbench top for the torus point distance block: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module torus_point_distance_top_tb;
   import tpd_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam longint ONE = 65536;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int fail_count, pending_count, result_count;
   int sent;
   bit no_gaps;
   longint torus_cx, torus_r;

   torus_point_distance_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tpd_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("** torus_point_distance_top: FAILED **");
      $finish;
   end

   task automatic write_reg(input reg_idx_type idx, input longint value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[31:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_torus(input longint cx, cy, cz, input longint ax, ay, az,
                            input longint major, minor);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_CENTER_Z, cz);
      write_reg(REG_AXIS_X, ax);
      write_reg(REG_AXIS_Y, ay);
      write_reg(REG_AXIS_Z, az);
      write_reg(REG_MAJOR, major);
      write_reg(REG_MINOR, minor);
      torus_cx = cx;
      torus_r = major + minor;
      @(posedge clock);
   endtask

   // Start stays high after the transfer so back-to-back queries keep it up.
   task automatic send_point(input logic [1:0] mode, input longint x, y, z);
      start <= 1'b1;
      req_data <= '{mode: mode, point_x: x[31:0], point_y: y[31:0], point_z: z[31:0]};
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      if (!no_gaps && $urandom_range(99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   function automatic longint near_coord(input longint base);
      longint span;
      span = 3 * torus_r + ONE;
      if (span > 64'sd1000000000) span = 64'sd1000000000;
      if ($urandom_range(9) < 2) return longint'($signed($urandom()));
      return base + longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic random_points(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 && $urandom_range(1) == 1) wait_idle();
         send_point(2'($urandom_range(3)), near_coord(torus_cx), near_coord(0),
                    near_coord(0));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sent = 0;
      no_gaps = 1'b0;
      torus_cx = 0;
      torus_r = 2 * ONE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unit torus after reset: center, ring, tube, extremes and the spare mode.
      send_point(MODE_DIST, 0, 0, 0);
      send_point(MODE_SQUARE, 0, 0, 0);
      send_point(MODE_TEST, 0, 0, 0);
      send_point(MODE_SPARE, 0, 0, 0);
      send_point(MODE_DIST, ONE, 0, 0);
      send_point(MODE_SQUARE, ONE, 0, 0);
      send_point(MODE_TEST, ONE, 0, 0);
      send_point(MODE_DIST, 2 * ONE, 0, 0);
      send_point(MODE_DIST, 0, 0, ONE);
      send_point(MODE_SQUARE, 5 * ONE / 2, 0, 0);
      send_point(MODE_SQUARE, ONE / 2, ONE / 2, 0);
      send_point(MODE_SPARE, 5 * ONE, ONE, 0);
      send_point(MODE_DIST, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
      send_point(MODE_SQUARE, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
      send_point(MODE_TEST, 64'sd2147483647, 0, 0);
      send_point(MODE_DIST, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
      send_point(MODE_SQUARE, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
      send_point(MODE_SQUARE, -64'sd2147483648, 64'sd2147483647, 0);
      send_point(MODE_DIST, 0, -ONE, -ONE / 2);
      random_points(80);
      wait_idle();

      set_torus(5 * ONE, -3 * ONE, 2 * ONE, 32767, 0, 0, 3 * ONE, ONE / 2);
      random_points(100);
      wait_idle();

      // An axis far from unit length drives the radial argument negative.
      no_gaps = 1'b1;
      set_torus(0, 0, 0, -32768, -32768, -32768, 2 * ONE, ONE);
      send_point(MODE_DIST, ONE, ONE, ONE);
      random_points(100);
      no_gaps = 1'b0;
      wait_idle();

      set_torus(ONE, ONE, -ONE, 0, 0, -32768, 0, 0);
      random_points(90);
      wait_idle();

      set_torus(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, 23170, 0, 23170,
                64'sd2147483647, 64'sd2147483647);
      send_point(MODE_DIST, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
      send_point(MODE_SQUARE, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648);
      random_points(90);
      wait_idle();

      set_torus(longint'($signed($urandom())), longint'($signed($urandom())),
                longint'($signed($urandom())), $urandom_range(0, 65535) - 32768,
                $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                $urandom_range(0, 32'h7fffffff), $urandom_range(0, 32'h7fffffff));
      random_points(120);
      wait_idle();

      set_torus(-64'sd2147483648, 0, 0, 0, 32767, 0, 64'sd2147483647, 0);
      random_points(90);
      wait_idle();

      $display("Sent %0d queries over seven torus settings; %0d responses checked.",
               sent, result_count);
      $display("Settings covered reset values, unnormalized axes, zero and full radii.");
      if (fail_count == 0) begin
         $display("** torus_point_distance_top: PASSED **");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("** torus_point_distance_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/tpd_pkg.sv
src/tpd_sqrt.sv
src/tpd_fifo.sv
src/tpd_front.sv
src/tpd_back.sv
src/torus_point_distance_top.sv
src/tpd_checker.sv
sim/tpd_checker.sv
sim/torus_point_distance_top_tb.sv
